// ----- design/pfj_pkg.sv -----
// ----------------------------------------------------------------------------
// pfj_pkg: shared types, constants and arithmetic helpers
// Widths, step codes, command/status bundles and saturation functions for
// the pairwise force and jerk accumulator.
// ----------------------------------------------------------------------------
package pfj_pkg;

  localparam int LEVELS      = 2;
  localparam int FRAC_BITS   = 16;
  localparam int DATA_W      = 32;
  localparam int ACC_W       = 64;
  localparam int WIDE_W      = 128;
  localparam int MUL_B_W     = 64;
  localparam int DIFF_W      = DATA_W + 1;
  localparam int R_W         = 34;
  localparam int P_W         = 2 * DIFF_W;
  localparam int Q_SHIFT     = 32;
  localparam int DIV_STEPS   = WIDE_W;
  localparam int SQRT_STEPS  = R_W;
  localparam int SQRT_IN_W   = 2 * SQRT_STEPS;
  localparam int CNT_W       = $clog2(DIV_STEPS + 1);
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SOFTENING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_JERK      = 1'b1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } op_t;

  typedef enum logic [4:0] {
    ST_QQ   = 5'd0,
    ST_DX2  = 5'd1,
    ST_DY2  = 5'd2,
    ST_SQRT = 5'd3,
    ST_RR   = 5'd4,
    ST_RRR  = 5'd5,
    ST_NFX  = 5'd6,
    ST_DFX  = 5'd7,
    ST_NFY  = 5'd8,
    ST_DFY  = 5'd9,
    ST_P1   = 5'd10,
    ST_P2   = 5'd11,
    ST_DU   = 5'd12,
    ST_T2X  = 5'd13,
    ST_T2Y  = 5'd14,
    ST_NJX  = 5'd15,
    ST_DJX  = 5'd16,
    ST_NJY  = 5'd17,
    ST_DJY  = 5'd18
  } step_t;

  typedef struct packed {
    logic  in_ready;
    logic  start;
    step_t step;
    logic  emit;
  } cmd_t;

  typedef struct packed {
    logic go;
    logic last;
    logic jerk_en;
    logic r2_zero;
    logic unit_done;
    logic unit_idle;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic                     kind;
    logic                     level;
    logic signed [DATA_W-1:0] pos_x;
    logic signed [DATA_W-1:0] pos_y;
    logic signed [DATA_W-1:0] mom_x;
    logic signed [DATA_W-1:0] mom_y;
    logic signed [DATA_W-1:0] charge;
    logic                     last;
  } in_item_t;

  typedef struct packed {
    logic                    out_level;
    logic signed [ACC_W-1:0] force_x;
    logic signed [ACC_W-1:0] force_y;
    logic signed [ACC_W-1:0] jerk_x;
    logic signed [ACC_W-1:0] jerk_y;
    logic                    overflow;
  } out_item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] val;
    logic                    ovf;
  } sat_t;

  // Which shared-unit operation a step runs
  function automatic op_t step_op(input step_t s);
    op_t o;
    unique case (s)
      ST_SQRT:                              o = OP_SQRT;
      ST_DFX, ST_DFY, ST_DU, ST_DJX, ST_DJY: o = OP_DIV;
      default:                              o = OP_MUL;
    endcase
    return o;
  endfunction

  function automatic logic [DIFF_W-1:0] abs_d(input logic signed [DIFF_W-1:0] v);
    return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
  endfunction

  function automatic logic [ACC_W-1:0] abs_a(input logic signed [ACC_W-1:0] v);
    return v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
  endfunction

  // Clamp a magnitude with sign into the signed accumulator range
  function automatic sat_t to_sat(input logic [WIDE_W-1:0] mag, input logic neg);
    sat_t s;
    if (|mag[WIDE_W-1:ACC_W-1]) begin
      s.ovf = 1'b1;
      s.val = neg ? ACC_MIN : ACC_MAX;
    end else begin
      s.ovf = 1'b0;
      s.val = neg ? -$signed(mag[ACC_W-1:0]) : $signed(mag[ACC_W-1:0]);
    end
    return s;
  endfunction

  function automatic sat_t sat_add(input logic signed [ACC_W-1:0] a,
                                   input logic signed [ACC_W-1:0] b);
    sat_t s;
    logic signed [ACC_W-1:0] sum;
    sum   = a + b;
    s.ovf = (a[ACC_W-1] == b[ACC_W-1]) && (sum[ACC_W-1] != a[ACC_W-1]);
    s.val = s.ovf ? (b[ACC_W-1] ? ACC_MIN : ACC_MAX) : sum;
    return s;
  endfunction

  function automatic sat_t sat_sub(input logic signed [ACC_W-1:0] a,
                                   input logic signed [ACC_W-1:0] b);
    sat_t s;
    logic signed [ACC_W-1:0] dif;
    dif   = a - b;
    s.ovf = (a[ACC_W-1] != b[ACC_W-1]) && (dif[ACC_W-1] != a[ACC_W-1]);
    s.val = s.ovf ? (b[ACC_W-1] ? ACC_MAX : ACC_MIN) : dif;
    return s;
  endfunction

endpackage

// ----- design/pfj_if.sv -----
// ----------------------------------------------------------------------------
// pfj_if: valid/ready channel interfaces
// Particle item channel and result channel of the accumulator.
// ----------------------------------------------------------------------------
interface pfj_in_if import pfj_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     kind;
  logic                     level;
  logic signed [DATA_W-1:0] pos_x;
  logic signed [DATA_W-1:0] pos_y;
  logic signed [DATA_W-1:0] mom_x;
  logic signed [DATA_W-1:0] mom_y;
  logic signed [DATA_W-1:0] charge;
  logic                     last;

  modport source (output valid, kind, level, pos_x, pos_y, mom_x, mom_y, charge, last,
                  input ready);
  modport sink   (input valid, kind, level, pos_x, pos_y, mom_x, mom_y, charge, last,
                  output ready);
endinterface

interface pfj_out_if import pfj_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    out_level;
  logic signed [ACC_W-1:0] force_x;
  logic signed [ACC_W-1:0] force_y;
  logic signed [ACC_W-1:0] jerk_x;
  logic signed [ACC_W-1:0] jerk_y;
  logic                    overflow;

  modport source (output valid, out_level, force_x, force_y, jerk_x, jerk_y, overflow,
                  input ready);
  modport sink   (input valid, out_level, force_x, force_y, jerk_x, jerk_y, overflow,
                  output ready);
endinterface

// ----- design/pfj_arith.sv -----
// ----------------------------------------------------------------------------
// pfj_arith: shared iterative arithmetic unit
// Shift-add multiply (one multiplier bit per cycle, stops when the rest is
// zero), restoring 128-bit divide and digit-by-digit floor square root.
// ----------------------------------------------------------------------------
module pfj_arith import pfj_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  op_t               op,
  input  logic [WIDE_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  input  logic [WIDE_W-1:0] d,
  output logic              done,
  output logic              idle,
  output logic [WIDE_W-1:0] res
);

  logic               busy_r;
  op_t                op_r;
  logic [WIDE_W-1:0]  a_r;
  logic [MUL_B_W-1:0] b_r;
  logic [WIDE_W-1:0]  d_r;
  logic [WIDE_W-1:0]  p_r;
  logic [WIDE_W-1:0]  rem_r;
  logic [CNT_W-1:0]   cnt_r;

  logic [WIDE_W-1:0]  div_rs;
  logic               div_ge;
  logic [WIDE_W-1:0]  sq_rs;
  logic [WIDE_W-1:0]  sq_trial;
  logic               sq_ge;

  // Trial remainders for divide and square root
  assign div_rs   = {rem_r[WIDE_W-2:0], a_r[WIDE_W-1]};
  assign div_ge   = (div_rs >= d_r);
  assign sq_rs    = {rem_r[WIDE_W-3:0], a_r[WIDE_W-1 -: 2]};
  assign sq_trial = {p_r[WIDE_W-3:0], 2'b01};
  assign sq_ge    = (sq_rs >= sq_trial);

  assign done = busy_r && ((op_r == OP_MUL) ? (b_r == '0) : (cnt_r == '0));
  assign idle = !busy_r;
  assign res  = p_r;

  // Track busy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  // Load operands, then advance one step a cycle
  always_ff @(posedge clk) begin
    if (start) begin
      op_r  <= op;
      p_r   <= '0;
      rem_r <= '0;
      a_r   <= (op == OP_SQRT) ? (a << (WIDE_W - SQRT_IN_W)) : a;
      b_r   <= b;
      d_r   <= d;
      cnt_r <= (op == OP_SQRT) ? CNT_W'(SQRT_STEPS) : CNT_W'(DIV_STEPS);
    end else if (busy_r && !done) begin
      case (op_r)
        OP_MUL: begin
          if (b_r[0]) p_r <= p_r + a_r;
          a_r <= a_r << 1;
          b_r <= b_r >> 1;
        end
        OP_DIV: begin
          rem_r <= div_ge ? (div_rs - d_r) : div_rs;
          p_r   <= {p_r[WIDE_W-2:0], div_ge};
          a_r   <= a_r << 1;
          cnt_r <= cnt_r - 1'b1;
        end
        OP_SQRT: begin
          rem_r <= sq_ge ? (sq_rs - sq_trial) : sq_rs;
          p_r   <= {p_r[WIDE_W-2:0], sq_ge};
          a_r   <= a_r << 2;
          cnt_r <= cnt_r - 1'b1;
        end
        default: begin
          cnt_r <= '0;
        end
      endcase
    end
  end

endmodule

// ----- design/pfj_datapath.sv -----
// ----------------------------------------------------------------------------
// pfj_datapath: particle state, work registers and result register
// Holds per-level targets and sums, feeds the shared unit for each step
// and writes its result back with saturation.
// ----------------------------------------------------------------------------
module pfj_datapath import pfj_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  in_item_t             in_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  cmd_t                 cmd,
  output stat_t                stat,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item
);

  // Per-level architectural state
  logic signed [DATA_W-1:0] tpx_r [LEVELS];
  logic signed [DATA_W-1:0] tpy_r [LEVELS];
  logic signed [DATA_W-1:0] tmx_r [LEVELS];
  logic signed [DATA_W-1:0] tmy_r [LEVELS];
  logic signed [DATA_W-1:0] tq_a_r [LEVELS];
  logic signed [ACC_W-1:0]  acc_fx_r [LEVELS];
  logic signed [ACC_W-1:0]  acc_fy_r [LEVELS];
  logic signed [ACC_W-1:0]  acc_jx_r [LEVELS];
  logic signed [ACC_W-1:0]  acc_jy_r [LEVELS];
  logic                     ovf_r [LEVELS];

  logic [CFG_W-1:0] soft_r;
  logic             jerk_r;

  // Work registers of the current interaction
  logic                     lv_r;
  logic                     last_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dpx_r, dpy_r;
  logic signed [DATA_W-1:0] tq_r, sq_r;
  logic [ACC_W-1:0]         qq_r;
  logic [WIDE_W-1:0]        r2_r;
  logic [R_W-1:0]           r_r;
  logic [WIDE_W-1:0]        r3_r;
  logic [WIDE_W-1:0]        num_r;
  logic [P_W-1:0]           p1_r;
  logic                     dn_r;
  logic signed [ACC_W-1:0]  fx_r, fy_r, u_r, t2x_r, t2y_r;

  logic                out_valid_r;
  out_item_t           out_item_r;

  logic                accept;
  logic                in_lv_ok;
  logic                unit_done;
  logic                unit_idle;
  logic [WIDE_W-1:0]   res;
  logic [WIDE_W-1:0]   a_op;
  logic [MUL_B_W-1:0]  b_op;
  logic [WIDE_W-1:0]   d_op;

  logic                qq_neg;
  logic [WIDE_W-1:0]   r2_sum;
  logic                n1, n2, dm_neg;
  logic [P_W-1:0]      p2, dm;
  logic [WIDE_W-1:0]   res3;
  logic [WIDE_W-1:0]   t2_mag;
  logic                neg_sel;
  logic [WIDE_W-1:0]   sat_in;
  logic signed [ACC_W-1:0] acc_old;
  logic signed [ACC_W-1:0] t2_sel;
  sat_t                sq, s1, s2;

  assign accept   = in_valid && cmd.in_ready;
  assign in_lv_ok = (int'(in_item.level) < LEVELS);

  pfj_arith u_arith (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start),
    .op    (step_op(cmd.step)),
    .a     (a_op),
    .b     (b_op),
    .d     (d_op),
    .done  (unit_done),
    .idle  (unit_idle),
    .res   (res)
  );

  // Select operands for the step in progress
  always_comb begin
    a_op = '0;
    b_op = '0;
    d_op = r3_r;
    case (cmd.step)
      ST_QQ: begin
        a_op = WIDE_W'(abs_d(DIFF_W'(tq_r)));
        b_op = MUL_B_W'(abs_d(DIFF_W'(sq_r)));
      end
      ST_DX2: begin
        a_op = WIDE_W'(abs_d(dx_r));
        b_op = MUL_B_W'(abs_d(dx_r));
      end
      ST_DY2: begin
        a_op = WIDE_W'(abs_d(dy_r));
        b_op = MUL_B_W'(abs_d(dy_r));
      end
      ST_SQRT: a_op = r2_r;
      ST_RR: begin
        a_op = WIDE_W'(r_r);
        b_op = MUL_B_W'(r_r);
      end
      ST_RRR: begin
        a_op = r3_r;
        b_op = MUL_B_W'(r_r);
      end
      ST_NFX: begin
        a_op = WIDE_W'(qq_r);
        b_op = MUL_B_W'(abs_d(dx_r));
      end
      ST_NFY: begin
        a_op = WIDE_W'(qq_r);
        b_op = MUL_B_W'(abs_d(dy_r));
      end
      ST_NJX: begin
        a_op = WIDE_W'(qq_r);
        b_op = MUL_B_W'(abs_d(dpx_r));
      end
      ST_NJY: begin
        a_op = WIDE_W'(qq_r);
        b_op = MUL_B_W'(abs_d(dpy_r));
      end
      ST_P1: begin
        a_op = WIDE_W'(abs_d(dpx_r));
        b_op = MUL_B_W'(abs_d(dx_r));
      end
      ST_P2: begin
        a_op = WIDE_W'(abs_d(dpy_r));
        b_op = MUL_B_W'(abs_d(dy_r));
      end
      ST_T2X: begin
        a_op = WIDE_W'(abs_a(u_r));
        b_op = abs_a(fx_r);
      end
      ST_T2Y: begin
        a_op = WIDE_W'(abs_a(u_r));
        b_op = abs_a(fy_r);
      end
      ST_DFX, ST_DFY, ST_DJX, ST_DJY: a_op = num_r;
      ST_DU: begin
        a_op = num_r;
        d_op = r2_r;
      end
      default: a_op = '0;
    endcase
  end

  // Write-back arithmetic
  always_comb begin
    qq_neg = tq_r[DATA_W-1] ^ sq_r[DATA_W-1];
    r2_sum = r2_r + res + ({{(WIDE_W-CFG_W){1'b0}}, soft_r} << FRAC_BITS);
    n1     = dpx_r[DIFF_W-1] ^ dx_r[DIFF_W-1];
    n2     = dpy_r[DIFF_W-1] ^ dy_r[DIFF_W-1];
    p2     = res[P_W-1:0];
    if (n1 == n2) begin
      dm     = p1_r + p2;
      dm_neg = n1;
    end else if (p1_r < p2) begin
      dm     = p2 - p1_r;
      dm_neg = n2;
    end else begin
      dm     = p1_r - p2;
      dm_neg = n1;
    end
    res3   = res + (res << 1);
    t2_mag = res3 >> Q_SHIFT;

    neg_sel = 1'b0;
    acc_old = '0;
    t2_sel  = '0;
    case (cmd.step)
      ST_DFX: begin
        neg_sel = dx_r[DIFF_W-1] ^ qq_neg;
        acc_old = acc_fx_r[lv_r];
      end
      ST_DFY: begin
        neg_sel = dy_r[DIFF_W-1] ^ qq_neg;
        acc_old = acc_fy_r[lv_r];
      end
      ST_DJX: begin
        neg_sel = dpx_r[DIFF_W-1] ^ qq_neg;
        acc_old = acc_jx_r[lv_r];
        t2_sel  = t2x_r;
      end
      ST_DJY: begin
        neg_sel = dpy_r[DIFF_W-1] ^ qq_neg;
        acc_old = acc_jy_r[lv_r];
        t2_sel  = t2y_r;
      end
      ST_DU:  neg_sel = dn_r;
      ST_T2X: neg_sel = u_r[ACC_W-1] ^ fx_r[ACC_W-1];
      ST_T2Y: neg_sel = u_r[ACC_W-1] ^ fy_r[ACC_W-1];
      default: neg_sel = 1'b0;
    endcase
    sat_in = ((cmd.step == ST_T2X) || (cmd.step == ST_T2Y)) ? t2_mag : res;
    sq     = to_sat(sat_in, neg_sel);
    s1     = sat_add(acc_old, sq.val);
    s2     = sat_sub(s1.val, t2_sel);
  end

  // Architectural state: config, loads and accumulation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soft_r <= CFG_W'(1);
      jerk_r <= 1'b1;
      for (int i = 0; i < LEVELS; i++) begin
        tpx_r[i]    <= '0;
        tpy_r[i]    <= '0;
        tmx_r[i]    <= '0;
        tmy_r[i]    <= '0;
        tq_a_r[i]   <= '0;
        acc_fx_r[i] <= '0;
        acc_fy_r[i] <= '0;
        acc_jx_r[i] <= '0;
        acc_jy_r[i] <= '0;
        ovf_r[i]    <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SOFTENING: soft_r <= cfg_data;
          CFG_JERK:      jerk_r <= cfg_data[0];
        endcase
      end
      // Load a target and clear its level
      if (accept && !in_item.kind && in_lv_ok) begin
        tpx_r[in_item.level]    <= in_item.pos_x;
        tpy_r[in_item.level]    <= in_item.pos_y;
        tmx_r[in_item.level]    <= in_item.mom_x;
        tmy_r[in_item.level]    <= in_item.mom_y;
        tq_a_r[in_item.level]   <= in_item.charge;
        acc_fx_r[in_item.level] <= '0;
        acc_fy_r[in_item.level] <= '0;
        acc_jx_r[in_item.level] <= '0;
        acc_jy_r[in_item.level] <= '0;
        ovf_r[in_item.level]    <= 1'b0;
      end
      // Accumulate sums on divide completion; overflow flags also on DU/T2X/T2Y
      if (unit_done) begin
        case (cmd.step)
          ST_DFX: begin
            acc_fx_r[lv_r] <= s1.val;
            ovf_r[lv_r]    <= ovf_r[lv_r] | sq.ovf | s1.ovf;
          end
          ST_DFY: begin
            acc_fy_r[lv_r] <= s1.val;
            ovf_r[lv_r]    <= ovf_r[lv_r] | sq.ovf | s1.ovf;
          end
          ST_DJX: begin
            acc_jx_r[lv_r] <= s2.val;
            ovf_r[lv_r]    <= ovf_r[lv_r] | sq.ovf | s1.ovf | s2.ovf;
          end
          ST_DJY: begin
            acc_jy_r[lv_r] <= s2.val;
            ovf_r[lv_r]    <= ovf_r[lv_r] | sq.ovf | s1.ovf | s2.ovf;
          end
          ST_DU, ST_T2X, ST_T2Y: ovf_r[lv_r] <= ovf_r[lv_r] | sq.ovf;
          default: ovf_r[lv_r] <= ovf_r[lv_r];
        endcase
      end
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    if (accept && in_item.kind) begin
      lv_r   <= in_item.level;
      last_r <= in_item.last;
      dx_r   <= DIFF_W'(tpx_r[in_item.level]) - DIFF_W'(in_item.pos_x);
      dy_r   <= DIFF_W'(tpy_r[in_item.level]) - DIFF_W'(in_item.pos_y);
      dpx_r  <= DIFF_W'(tmx_r[in_item.level]) - DIFF_W'(in_item.mom_x);
      dpy_r  <= DIFF_W'(tmy_r[in_item.level]) - DIFF_W'(in_item.mom_y);
      tq_r   <= tq_a_r[in_item.level];
      sq_r   <= in_item.charge;
    end
    if (unit_done) begin
      case (cmd.step)
        ST_QQ:   qq_r  <= res[ACC_W-1:0];
        ST_DX2:  r2_r  <= res;
        ST_DY2:  r2_r  <= r2_sum;
        ST_SQRT: r_r   <= res[R_W-1:0];
        ST_RR:   r3_r  <= res;
        ST_RRR:  r3_r  <= res;
        ST_NFX, ST_NFY, ST_NJX, ST_NJY: num_r <= res << Q_SHIFT;
        ST_DFX:  fx_r  <= sq.val;
        ST_DFY:  fy_r  <= sq.val;
        ST_P1:   p1_r  <= res[P_W-1:0];
        ST_P2: begin
          num_r <= WIDE_W'(dm) << Q_SHIFT;
          dn_r  <= dm_neg;
        end
        ST_DU:   u_r   <= sq.val;
        ST_T2X:  t2x_r <= sq.val;
        ST_T2Y:  t2y_r <= sq.val;
        default: num_r <= num_r;
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item_r.out_level <= lv_r;
      out_item_r.force_x   <= acc_fx_r[lv_r];
      out_item_r.force_y   <= acc_fy_r[lv_r];
      out_item_r.jerk_x    <= acc_jx_r[lv_r];
      out_item_r.jerk_y    <= acc_jy_r[lv_r];
      out_item_r.overflow  <= ovf_r[lv_r];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign stat.go        = in_item.kind && in_lv_ok;
  assign stat.last      = last_r;
  assign stat.jerk_en   = jerk_r;
  assign stat.r2_zero   = (r2_r == '0);
  assign stat.unit_done = unit_done;
  assign stat.unit_idle = unit_idle;
  assign stat.out_free  = !out_valid_r;

endmodule

// ----- design/pfj_ctrl.sv -----
// ----------------------------------------------------------------------------
// pfj_ctrl: interaction sequencer
// Walks the steps of one interaction over the shared unit and hands the
// sums to the result register.
// ----------------------------------------------------------------------------
module pfj_ctrl import pfj_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ISSUE  = 4'b0010,
    S_WAIT   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    step_nxt     = step_r;
    cmd.in_ready = 1'b0;
    cmd.start    = 1'b0;
    cmd.step     = step_r;
    cmd.emit     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (in_valid && stat.go) begin
          step_nxt  = ST_QQ;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        // Drop the pair when the softened squared distance is zero
        if ((step_r == ST_SQRT) && stat.r2_zero) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.start = 1'b1;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: begin
        if (stat.unit_done) begin
          if (((step_r == ST_DFY) && !stat.jerk_en) || (step_r == ST_DJY)) begin
            state_nxt = S_FINISH;
          end else begin
            step_nxt  = step_t'(step_r + 1'b1);
            state_nxt = S_ISSUE;
          end
        end
      end
      S_FINISH: begin
        if (!stat.last) begin
          state_nxt = S_IDLE;
        end else if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= ST_QQ;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// ----- design/pairwise_force_jerk_accumulator_top.sv -----
// ----------------------------------------------------------------------------
// pairwise_force_jerk_accumulator_top: Hermite pairwise force/jerk kernel
// Fixed-point softened Coulomb force and jerk sums per time level.
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    kind level pos_x pos_y mom_x mom_y charge last
//   out_ch   out  valid/ready    out_level force_x force_y jerk_x jerk_y overflow
//   cfg      in   cfg_we only    cfg_index cfg_data (softening, jerk_enable)
//
// An interaction runs 19 steps on one shared shift-add/restoring unit:
// five divides, a square root and multiplies that end once the remaining
// multiplier bits are zero. With jerk disabled it ends after the force steps;
// a pair whose softened squared distance is zero stops after the distance
// steps. Input is taken only between interactions.
// Reset is synchronous, active low; sums, targets and the overflow flags clear.
// A waiting result stalls only an interaction that must emit another result.
// ----------------------------------------------------------------------------
module pairwise_force_jerk_accumulator_top import pfj_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  pfj_in_if.sink               in_ch,
  pfj_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cmd_t      cmd;
  stat_t     stat;
  in_item_t  in_item;
  out_item_t out_item;

  // Bundle the input transaction
  assign in_item.kind   = in_ch.kind;
  assign in_item.level  = in_ch.level;
  assign in_item.pos_x  = in_ch.pos_x;
  assign in_item.pos_y  = in_ch.pos_y;
  assign in_item.mom_x  = in_ch.mom_x;
  assign in_item.mom_y  = in_ch.mom_y;
  assign in_item.charge = in_ch.charge;
  assign in_item.last   = in_ch.last;
  assign in_ch.ready    = cmd.in_ready;

  pfj_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  pfj_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item)
  );

  // Unbundle the result transaction
  assign out_ch.out_level = out_item.out_level;
  assign out_ch.force_x   = out_item.force_x;
  assign out_ch.force_y   = out_item.force_y;
  assign out_ch.jerk_x    = out_item.jerk_x;
  assign out_ch.jerk_y    = out_item.jerk_y;
  assign out_ch.overflow  = out_item.overflow;

`ifndef SYNTHESIS
  // A result loads only into an empty result register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_ch.valid)
    else $error("result emitted over a pending result");

  // An accepted interaction closes the input until it finishes
  a_busy_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && stat.go) |=> !in_ch.ready)
    else $error("input open during an interaction");

  // The shared unit is started only when idle
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> stat.unit_idle)
    else $error("shared unit started while busy");
`endif

endmodule

// ----- dv/pfj_tb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfj_tb_checker: force/jerk sum predictor and result comparator
// Watches the particle and result channels and the register port, keeps a
// shadow of the per-level targets and sums, predicts every emitted result
// and compares it field by field with what the block reports.
// ----------------------------------------------------------------------------
module pfj_tb_checker import pfj_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  pfj_in_if                    in_ch,
  pfj_out_if                   out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   sums_pending
);

  localparam logic signed [ACC_W-1:0] SUM_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SUM_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Shadow state per level
  logic signed [63:0] tgt_px [LEVELS];
  logic signed [63:0] tgt_py [LEVELS];
  logic signed [63:0] tgt_mx [LEVELS];
  logic signed [63:0] tgt_my [LEVELS];
  logic signed [63:0] tgt_q  [LEVELS];
  logic signed [63:0] sum_fx [LEVELS];
  logic signed [63:0] sum_fy [LEVELS];
  logic signed [63:0] sum_jx [LEVELS];
  logic signed [63:0] sum_jy [LEVELS];
  logic               sum_ovf[LEVELS];
  logic [31:0]        soft_q;
  logic               jerk_on;

  out_item_t expected_sums[$];
  int        mismatches;

  assign fail_count   = mismatches;
  assign sums_pending = expected_sums.size();

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Clamp magnitude plus sign into the signed 64-bit range
  function automatic logic signed [63:0] clamp(input logic [127:0] mag, input logic neg,
                                               inout logic fl);
    if (mag > 128'(SUM_MAX)) begin
      fl = 1'b1;
      return neg ? SUM_MIN : SUM_MAX;
    end
    return neg ? -$signed(mag[63:0]) : $signed(mag[63:0]);
  endfunction

  function automatic logic signed [63:0] add_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 inout logic fl);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s > 65'(SUM_MAX)) begin fl = 1'b1; return SUM_MAX; end
    if (s < 65'(SUM_MIN)) begin fl = 1'b1; return SUM_MIN; end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sub_sat(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 inout logic fl);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s > 65'(SUM_MAX)) begin fl = 1'b1; return SUM_MAX; end
    if (s < 65'(SUM_MIN)) begin fl = 1'b1; return SUM_MIN; end
    return s[63:0];
  endfunction

  // v*qq/r^3 in Q32.32, truncated toward zero
  function automatic logic signed [63:0] coulomb_term(input logic signed [63:0] v,
                                                      input logic signed [63:0] qq,
                                                      input logic [127:0] r3,
                                                      inout logic fl);
    logic [127:0] n;
    n = (128'(mag64(v)) * 128'(mag64(qq))) << 32;
    return clamp(n / r3, v[63] ^ qq[63], fl);
  endfunction

  // Add one source particle to the sums of a level
  task automatic add_pair(input int lv, input in_item_t it);
    logic               fl;
    logic signed [63:0] dx, dy, dpx, dpy, qq, fx, fy, u, t2x, t2y;
    logic [127:0]       r2, r3, p1, p2, dm, c2;
    logic [63:0]        r, c;
    logic               n1, n2, dn;
    fl  = 1'b0;
    dx  = tgt_px[lv] - 64'(it.pos_x);
    dy  = tgt_py[lv] - 64'(it.pos_y);
    dpx = tgt_mx[lv] - 64'(it.mom_x);
    dpy = tgt_my[lv] - 64'(it.mom_y);
    qq  = tgt_q[lv] * 64'(it.charge);
    r2  = 128'(mag64(dx)) * 128'(mag64(dx)) + 128'(mag64(dy)) * 128'(mag64(dy))
        + (128'(soft_q) << FRAC_BITS);
    // coincident particles with no softening contribute nothing
    if (r2 == '0) return;
    r = '0;
    for (int b = 33; b >= 0; b--) begin
      c  = r | (64'd1 << b);
      c2 = 128'(c) * 128'(c);
      if (c2 <= r2) r = c;
    end
    r3 = 128'(r) * 128'(r) * 128'(r);
    fx = coulomb_term(dx, qq, r3, fl);
    fy = coulomb_term(dy, qq, r3, fl);
    sum_fx[lv] = add_sat(sum_fx[lv], fx, fl);
    sum_fy[lv] = add_sat(sum_fy[lv], fy, fl);
    if (jerk_on) begin
      n1 = dpx[63] ^ dx[63];
      n2 = dpy[63] ^ dy[63];
      p1 = 128'(mag64(dpx)) * 128'(mag64(dx));
      p2 = 128'(mag64(dpy)) * 128'(mag64(dy));
      if (n1 == n2) begin
        dm = p1 + p2; dn = n1;
      end else if (p1 < p2) begin
        dm = p2 - p1; dn = n2;
      end else begin
        dm = p1 - p2; dn = n1;
      end
      u   = clamp((dm << 32) / r2, dn, fl);
      t2x = clamp(((128'(mag64(u)) * 128'(mag64(fx))) * 128'd3) >> 32, u[63] ^ fx[63], fl);
      t2y = clamp(((128'(mag64(u)) * 128'(mag64(fy))) * 128'd3) >> 32, u[63] ^ fy[63], fl);
      sum_jx[lv] = add_sat(sum_jx[lv], coulomb_term(dpx, qq, r3, fl), fl);
      sum_jx[lv] = sub_sat(sum_jx[lv], t2x, fl);
      sum_jy[lv] = add_sat(sum_jy[lv], coulomb_term(dpy, qq, r3, fl), fl);
      sum_jy[lv] = sub_sat(sum_jy[lv], t2y, fl);
    end
    if (fl) sum_ovf[lv] = 1'b1;
  endtask

  task automatic compare_sums(input out_item_t got);
    out_item_t want;
    if (expected_sums.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: unexpected result level=%0d fx=%h fy=%h", got.out_level,
                 got.force_x, got.force_y);
      return;
    end
    want = expected_sums.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: result mismatch at %0t", $realtime);
        $display("  level    exp %0d got %0d", want.out_level, got.out_level);
        $display("  force_x  exp %h got %h", want.force_x, got.force_x);
        $display("  force_y  exp %h got %h", want.force_y, got.force_y);
        $display("  jerk_x   exp %h got %h", want.jerk_x, got.jerk_x);
        $display("  jerk_y   exp %h got %h", want.jerk_y, got.jerk_y);
        $display("  overflow exp %0d got %0d", want.overflow, got.overflow);
      end
    end
  endtask

  // Track registers, check results, then predict on each accepted transaction
  always @(posedge clk) begin
    in_item_t  it;
    out_item_t res;
    int        lv;
    if (!rst_n) begin
      for (int i = 0; i < LEVELS; i++) begin
        tgt_px[i] = '0; tgt_py[i] = '0; tgt_mx[i] = '0; tgt_my[i] = '0; tgt_q[i] = '0;
        sum_fx[i] = '0; sum_fy[i] = '0; sum_jx[i] = '0; sum_jy[i] = '0;
        sum_ovf[i] = 1'b0;
      end
      soft_q  = 32'd1;
      jerk_on = 1'b1;
      expected_sums.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_SOFTENING) soft_q = cfg_data;
        else if (cfg_index == CFG_JERK) jerk_on = cfg_data[0];
      end
      if (out_ch.valid && out_ch.ready)
        compare_sums('{out_ch.out_level, out_ch.force_x, out_ch.force_y,
                       out_ch.jerk_x, out_ch.jerk_y, out_ch.overflow});
      if (in_ch.valid && in_ch.ready) begin
        it = '{in_ch.kind, in_ch.level, in_ch.pos_x, in_ch.pos_y, in_ch.mom_x,
               in_ch.mom_y, in_ch.charge, in_ch.last};
        lv = int'(it.level);
        if (lv < LEVELS) begin
          if (!it.kind) begin
            tgt_px[lv] = 64'(it.pos_x); tgt_py[lv] = 64'(it.pos_y);
            tgt_mx[lv] = 64'(it.mom_x); tgt_my[lv] = 64'(it.mom_y);
            tgt_q[lv]  = 64'(it.charge);
            sum_fx[lv] = '0; sum_fy[lv] = '0; sum_jx[lv] = '0; sum_jy[lv] = '0;
            sum_ovf[lv] = 1'b0;
          end else begin
            add_pair(lv, it);
            if (it.last) begin
              res = '{it.level, sum_fx[lv], sum_fy[lv], sum_jx[lv], sum_jy[lv],
                      sum_ovf[lv]};
              expected_sums.push_back(res);
            end
          end
        end
      end
    end
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: pairwise force/jerk accumulator stimulus and verdict
// Drives directed and random particle sequences through several register
// settings and handshake idling profiles; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import pfj_pkg::*;

  localparam int DRAIN_CYCLES = 2000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SOFTENING;
  logic [CFG_W-1:0]     cfg_data = '0;
  int                   fail_count;
  int                   sums_pending;
  int                   tx_idle_pct = 0;
  int                   rx_idle_pct = 0;

  pfj_in_if  in_ch ();
  pfj_out_if out_ch ();

  pairwise_force_jerk_accumulator_top uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pfj_tb_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .sums_pending(sums_pending)
  );

  always #5 clk = ~clk;

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.kind   = 1'b0;
    in_ch.level  = 1'b0;
    in_ch.pos_x  = '0;
    in_ch.pos_y  = '0;
    in_ch.mom_x  = '0;
    in_ch.mom_y  = '0;
    in_ch.charge = '0;
    in_ch.last   = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Hard limit on run time
  initial begin
    #250_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Offer one transaction and hold it until accepted
  task automatic send_particle(input logic kind, input logic lvl,
                               input logic [31:0] px, input logic [31:0] py,
                               input logic [31:0] mx, input logic [31:0] my,
                               input logic [31:0] q, input logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.kind   <= kind;
    in_ch.level  <= lvl;
    in_ch.pos_x  <= px;
    in_ch.pos_y  <= py;
    in_ch.mom_x  <= mx;
    in_ch.mom_y  <= my;
    in_ch.charge <= q;
    in_ch.last   <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drain all sums, let a trailing silent interaction finish, then write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sums_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly small coordinates, sometimes extremes or full range
  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 60) return 32'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
    if (sel < 70) return 32'h7FFF_FFFF;
    if (sel < 80) return 32'h8000_0000;
    return $urandom;
  endfunction

  task automatic random_phase(input int count);
    int   sent, n;
    logic lvl;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(9) == 0) begin
        // noise: any item, any field
        send_particle(1'($urandom), 1'($urandom), $urandom, $urandom, $urandom, $urandom,
                      $urandom, 1'($urandom));
        sent++;
      end else begin
        lvl = 1'($urandom);
        send_particle(1'b0, lvl, pick_value(), pick_value(), pick_value(), pick_value(),
                      pick_value(), 1'($urandom));
        n = $urandom_range(1, 5);
        for (int k = 0; k < n; k++)
          send_particle(1'b1, lvl, pick_value(), pick_value(), pick_value(), pick_value(),
                        pick_value(), (k == n - 1) || ($urandom_range(3) == 0));
        sent += n + 1;
      end
    end
  endtask

  initial begin
    logic [31:0] soft_set [6];
    logic        jerk_set [6];
    soft_set = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'h0001_0000, 32'd0};
    jerk_set = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero softening so coincident particles are reachable
    write_reg(CFG_SOFTENING, 32'd0);
    send_particle(1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0, 32'h0001_0000, 1'b0);
    send_particle(1'b1, 1'b0, 32'd0, 32'd0, 32'h0001_0000, 32'd0, 32'h0001_0000, 1'b1);
    send_particle(1'b0, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 1'b1);
    send_particle(1'b1, 1'b1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 1'b0);
    send_particle(1'b1, 1'b1, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 1'b1);
    send_particle(1'b1, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd0,
                  32'h8000_0000, 1'b1);
    send_particle(1'b0, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h8000_0000, 1'b0);
    send_particle(1'b1, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 1'b1);
    send_particle(1'b0, 1'b0, 32'h0001_0000, 32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000,
                  32'h0001_0000, 1'b1);
    send_particle(1'b1, 1'b0, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000, 32'd0,
                  32'hFFFF_0000, 1'b1);
    send_particle(1'b1, 1'b0, 32'h0001_0001, 32'h0001_0000, 32'd0, 32'h0001_0000,
                  32'h7FFF_FFFF, 1'b1);
    send_particle(1'b1, 1'b0, 32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0,
                  32'h0001_0000, 1'b1);
    send_particle(1'b1, 1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1'b1);
    send_particle(1'b0, 1'b1, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF,
                  1'b0);
    send_particle(1'b1, 1'b1, 32'd1, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd1, 1'b1);

    // Random phases over register settings and idling profiles
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_SOFTENING, (ph == 3) ? $urandom : soft_set[ph]);
      write_reg(CFG_JERK, {31'd0, jerk_set[ph]});
      tx_idle_pct = (ph < 2) ? 13 : (ph < 4) ? 71 : 0;
      rx_idle_pct = (ph < 2) ? 71 : (ph < 4) ? 13 : 0;
      random_phase(272);
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sums_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- pairwise_force_jerk_accumulator_top.f -----
design/pfj_pkg.sv
design/pfj_if.sv
design/pfj_arith.sv
design/pfj_datapath.sv
design/pfj_ctrl.sv
design/pairwise_force_jerk_accumulator_top.sv
dv/pfj_tb_checker.sv
dv/testbench.sv
